[rtl/crtl_pkg.sv]
// crtl_pkg: shared types and constants of the case run table lookup.
// Used by crtl_engine, case_run_table_lookup and the testbench; depends on nothing.

package crtl_pkg;

   // field widths fixed by the item format
   localparam int CODE_W  = 21;
   localparam int DELTA_W = 17;
   localparam int INDEX_W = 9;
   localparam int COUNT_W = 10;
   localparam int SUM_W   = CODE_W + 2;

   localparam int REQ_TDATA_W = 96;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 2;

   // last valid Unicode scalar
   localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;

   // operation codes carried in req_tuser[0]
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // table selector carried in req_tuser[1]
   localparam logic TABLE_UPPER = 1'b0;
   localparam logic TABLE_LOWER = 1'b1;

   // configuration register indexes
   localparam logic CSR_UPPER_COUNT = 1'b0;
   localparam logic CSR_LOWER_COUNT = 1'b1;

   // one stored run, 60 bits
   typedef struct packed {
      logic [CODE_W-1:0]         first;
      logic [CODE_W-1:0]         last;
      logic                      alt;
      logic signed [DELTA_W-1:0] delta;
   } run_entry_type;

   // one input beat, unpacked
   typedef struct packed {
      logic                      func;
      logic                      table_sel;
      logic [INDEX_W-1:0]        entry_index;
      logic [CODE_W-1:0]         run_start;
      logic [CODE_W-1:0]         run_end;
      logic                      every_other;
      logic signed [DELTA_W-1:0] run_delta;
      logic [CODE_W-1:0]         code_point;
   } req_item_type;

   // one result beat, unpacked
   typedef struct packed {
      logic [CODE_W-1:0] mapped_code;
      logic              was_mapped;
      logic              range_error;
   } rsp_item_type;

endpackage

[rtl/crtl_ram.sv]
// crtl_ram: generic single-port synchronous RAM, registered read.
// No dependencies.

module crtl_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read share one address
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/crtl_engine.sv]
// crtl_engine: load writes and binary search sequencer over the run memory.
// Depends on crtl_pkg; drives the port of one crtl_ram instance.

module crtl_engine
   import crtl_pkg::*;
#(
   parameter int RUNS_PER_TABLE = 512,
   parameter int MEM_AW         = $clog2(2 * RUNS_PER_TABLE)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [COUNT_W-1:0]  upper_count,
   input  logic [COUNT_W-1:0]  lower_count,
   input  logic                item_valid,
   output logic                item_ready,
   input  req_item_type        item,
   output logic                res_valid,
   input  logic                res_ready,
   output rsp_item_type        res,
   output logic                ram_we,
   output logic [MEM_AW-1:0]   ram_addr,
   output run_entry_type       ram_wdata,
   input  run_entry_type       ram_rdata
);

   // lo/hi bounds must hold the run count itself
   localparam int CW = $clog2(RUNS_PER_TABLE + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     mid_ff, mid_in;
   logic [CODE_W-1:0] cp_ff, cp_in;
   logic [MEM_AW-1:0] base_ff, base_in;
   rsp_item_type      res_ff, res_in;

   logic [COUNT_W-1:0] sel_count;
   logic [CW-1:0]      sat_count;
   logic [MEM_AW-1:0]  item_base;
   logic               accept;
   logic               slot_ok;

   logic               below, above, parity_ok;
   logic signed [SUM_W-1:0] sum;
   logic               sum_err;
   logic [CW-1:0]      lo_r, mid_r, mid_l;
   logic               cont_r, cont_l;

   function automatic logic [CW-1:0] midpoint(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW:1];
   endfunction

   // count of the chosen table, saturated to the table size
   always_comb begin
      sel_count = (item.table_sel == TABLE_LOWER) ? lower_count : upper_count;
      if (32'(sel_count) > 32'(RUNS_PER_TABLE)) begin
         sat_count = CW'(RUNS_PER_TABLE);
      end else begin
         sat_count = CW'(sel_count);
      end
      item_base = (item.table_sel == TABLE_LOWER) ? MEM_AW'(RUNS_PER_TABLE) : '0;
      accept    = item_valid && item_ready;
      slot_ok   = 32'(item.entry_index) < 32'(RUNS_PER_TABLE);
   end

   // probe evaluation; both next midpoints are formed beside the compare
   always_comb begin
      below     = cp_ff < ram_rdata.first;
      above     = cp_ff > ram_rdata.last;
      parity_ok = !ram_rdata.alt || (cp_ff[0] == ram_rdata.first[0]);
      sum       = $signed({2'b00, cp_ff})
                + $signed({{(SUM_W - DELTA_W){ram_rdata.delta[DELTA_W-1]}}, ram_rdata.delta});
      sum_err   = sum[SUM_W-1] || (sum[SUM_W-2:0] > {1'b0, CODE_MAX});
      lo_r      = mid_ff + CW'(1);
      mid_r     = midpoint(lo_r, hi_ff);
      cont_r    = lo_r < hi_ff;
      mid_l     = midpoint(lo_ff, mid_ff);
      cont_l    = lo_ff < mid_ff;
   end

   // sequencer: loads write at accept, queries probe once per cycle
   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      cp_in     = cp_ff;
      base_in   = base_ff;
      res_in    = res_ff;
      ram_we    = 1'b0;
      ram_addr  = base_ff + MEM_AW'(mid_ff);
      ram_wdata.first = item.run_start;
      ram_wdata.last  = item.run_end;
      ram_wdata.alt   = item.every_other;
      ram_wdata.delta = item.run_delta;

      case (state_ff)
         ST_IDLE: begin
            if (item.func == FUNC_LOAD) begin
               ram_addr = item_base + MEM_AW'(item.entry_index);
               ram_we   = accept && slot_ok;
            end else begin
               ram_addr = item_base + MEM_AW'(sat_count >> 1);
               if (accept) begin
                  cp_in   = item.code_point;
                  base_in = item_base;
                  lo_in   = '0;
                  hi_in   = sat_count;
                  mid_in  = sat_count >> 1;
                  res_in.mapped_code = item.code_point;
                  res_in.was_mapped  = 1'b0;
                  res_in.range_error = 1'b0;
                  state_in = (sat_count == '0) ? ST_DONE : ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            res_in.mapped_code = cp_ff;
            res_in.was_mapped  = 1'b0;
            res_in.range_error = 1'b0;
            if (below) begin
               hi_in    = mid_ff;
               mid_in   = mid_l;
               ram_addr = base_ff + MEM_AW'(mid_l);
               state_in = cont_l ? ST_EVAL : ST_DONE;
            end else if (above) begin
               lo_in    = lo_r;
               mid_in   = mid_r;
               ram_addr = base_ff + MEM_AW'(mid_r);
               state_in = cont_r ? ST_EVAL : ST_DONE;
            end else begin
               // inside the run: wrong parity or out-of-range sum leaves cp as is
               if (parity_ok) begin
                  if (sum_err) begin
                     res_in.range_error = 1'b1;
                  end else begin
                     res_in.mapped_code = sum[CODE_W-1:0];
                     res_in.was_mapped  = 1'b1;
                  end
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      cp_ff   <= cp_in;
      base_ff <= base_in;
      res_ff  <= res_in;
   end

   assign item_ready = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_DONE);
   assign res        = res_ff;

endmodule

[rtl/case_run_table_lookup.sv]
// case_run_table_lookup: top level, beat packing, count registers, result register.
// Depends on crtl_pkg, crtl_ram and crtl_engine.
//
//   channel  | ports                        | direction | moves
//   req_     | tvalid tready tdata tuser    | in        | load or query beat
//   rsp_     | tvalid tready tdata tuser    | out       | one beat per query
//   csr_     | we index wdata               | in        | run count writes
//
// A load is written to the run memory at accept. A query is accepted, then makes
// P memory probes (up to log2(RUNS_PER_TABLE)+1, ten for 512 runs), each one
// read of the single-port run memory, then offers its result. Reads and writes
// never overlap since writes happen only at accept while the sequencer is idle.
// Reset clears the sequencer state, the counts and the result valid flag; the
// run memory and the result data are not cleared. A stalled rsp_ holds the
// result; the sequencer can take the next beat while that result waits.

module case_run_table_lookup
   import crtl_pkg::*;
#(
   parameter int RUNS_PER_TABLE = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [8:0] entry_index, [29:9] run_start, [50:30] run_end, [51] every_other,
   // [68:52] run_delta, [89:69] code_point, [95:90] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] func, [1] table_sel
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [20:0] mapped_code, [23:21] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] was_mapped, [1] range_error
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [COUNT_W-1:0]     csr_wdata
);

   localparam int MEM_AW = $clog2(2 * RUNS_PER_TABLE);
   localparam int DEPTH  = 2 * RUNS_PER_TABLE;

   logic [COUNT_W-1:0] upper_count_ff, upper_count_in;
   logic [COUNT_W-1:0] lower_count_ff, lower_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   req_item_type       item;
   rsp_item_type       res;
   logic               res_valid, res_ready;
   logic               ram_we;
   logic [MEM_AW-1:0]  ram_addr;
   run_entry_type      ram_wdata, ram_rdata;

   // unpack the input beat
   always_comb begin
      item.func        = req_tuser[0];
      item.table_sel   = req_tuser[1];
      item.entry_index = req_tdata[8:0];
      item.run_start   = req_tdata[29:9];
      item.run_end     = req_tdata[50:30];
      item.every_other = req_tdata[51];
      item.run_delta   = $signed(req_tdata[68:52]);
      item.code_point  = req_tdata[89:69];
   end

   // run count registers
   always_comb begin
      upper_count_in = upper_count_ff;
      lower_count_in = lower_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_UPPER_COUNT: upper_count_in = csr_wdata;
            CSR_LOWER_COUNT: lower_count_in = csr_wdata;
            default: begin
               upper_count_in = upper_count_ff;
            end
         endcase
      end
   end

   crtl_ram #(
      .WIDTH ($bits(run_entry_type)),
      .DEPTH (DEPTH)
   ) u_run_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   crtl_engine #(
      .RUNS_PER_TABLE (RUNS_PER_TABLE),
      .MEM_AW         (MEM_AW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .upper_count (upper_count_ff),
      .lower_count (lower_count_ff),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .item        (item),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .ram_we      (ram_we),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .ram_rdata   (ram_rdata)
   );

   // output register: loads when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_count_ff <= '0;
         lower_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         upper_count_ff <= upper_count_in;
         lower_count_ff <= lower_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - CODE_W){1'b0}}, rsp_data_ff.mapped_code};
   assign rsp_tuser  = {rsp_data_ff.range_error, rsp_data_ff.was_mapped};

endmodule

[tb/sv/case_map_checker.sv]
// case_map_checker: watches the req_, rsp_ and csr_ ports of case_run_table_lookup,
// keeps its own copy of both run tables and the counts, and checks every result beat.
// Depends on crtl_pkg.

module case_map_checker
   import crtl_pkg::*;
#(
   parameter int RUNS_PER_TABLE = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [COUNT_W-1:0]     csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow run tables, indexed by table selector then slot
   run_entry_type      run_mem [2][RUNS_PER_TABLE];
   logic [COUNT_W-1:0] upper_count;
   logic [COUNT_W-1:0] lower_count;
   rsp_item_type       expected_maps [$];

   // binary search of one table, then delta and range check
   function automatic rsp_item_type lookup_case(input logic sel, input logic [CODE_W-1:0] cp);
      rsp_item_type      res;
      run_entry_type     run;
      int                lo, hi, mid, limit, cp_i, delta_i, sum, code_top;
      logic [CODE_W-1:0] offset;
      bit                done, found;
      res.mapped_code = cp;
      res.was_mapped  = 1'b0;
      res.range_error = 1'b0;
      limit = (sel == TABLE_LOWER) ? int'(lower_count) : int'(upper_count);
      if (limit > RUNS_PER_TABLE) limit = RUNS_PER_TABLE;
      lo = 0;
      hi = limit;
      done = 1'b0;
      found = 1'b0;
      delta_i = 0;
      while (lo < hi && !done) begin
         mid = (lo + hi) / 2;
         run = run_mem[sel][mid];
         if (cp < run.first) begin
            hi = mid;
         end else if (cp > run.last) begin
            lo = mid + 1;
         end else begin
            done = 1'b1;
            offset = cp - run.first;
            // odd offset in an every-other run does not map
            if (!(run.alt && offset[0])) begin
               found = 1'b1;
               delta_i = run.delta;
            end
         end
      end
      if (found) begin
         cp_i = cp;
         code_top = CODE_MAX;
         sum = cp_i + delta_i;
         if (sum < 0 || sum > code_top) begin
            res.range_error = 1'b1;
         end else begin
            res.mapped_code = sum[CODE_W-1:0];
            res.was_mapped  = 1'b1;
         end
      end
      return res;
   endfunction

   // sample all channels at the rising edge
   always @(posedge clock) begin : monitor
      run_entry_type      entry;
      rsp_item_type       want, got;
      logic [INDEX_W-1:0] slot;
      if (reset) begin
         upper_count = '0;
         lower_count = '0;
         expected_maps.delete();
         fail_count = 0;
      end else begin
         // count register writes
         if (csr_we) begin
            if (csr_index == CSR_UPPER_COUNT) upper_count = csr_wdata;
            else lower_count = csr_wdata;
         end
         // accepted request beat: store a run or predict a mapping
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == FUNC_LOAD) begin
               slot        = req_tdata[8:0];
               entry.first = req_tdata[29:9];
               entry.last  = req_tdata[50:30];
               entry.alt   = req_tdata[51];
               entry.delta = req_tdata[68:52];
               if (slot < RUNS_PER_TABLE) run_mem[req_tuser[1]][slot] = entry;
            end else begin
               expected_maps.push_back(lookup_case(req_tuser[1], req_tdata[89:69]));
            end
         end
         // accepted result beat: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.mapped_code = rsp_tdata[CODE_W-1:0];
            got.was_mapped  = rsp_tuser[0];
            got.range_error = rsp_tuser[1];
            if (expected_maps.size() == 0) begin
               $display("%0t: result beat with nothing expected: mapped_code %h flags %b%b",
                        $time, got.mapped_code, got.range_error, got.was_mapped);
               fail_count++;
            end else begin
               want = expected_maps.pop_front();
               if (got.mapped_code !== want.mapped_code) begin
                  $display("%0t: mapped_code expected %h actual %h",
                           $time, want.mapped_code, got.mapped_code);
                  fail_count++;
               end
               if (got.was_mapped !== want.was_mapped) begin
                  $display("%0t: was_mapped expected %b actual %b",
                           $time, want.was_mapped, got.was_mapped);
                  fail_count++;
               end
               if (got.range_error !== want.range_error) begin
                  $display("%0t: range_error expected %b actual %b",
                           $time, want.range_error, got.range_error);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_maps.size();
   end

endmodule

[tb/sv/tb_case_run_table_lookup.sv]
// tb_case_run_table_lookup: clock, reset and stimulus for case_run_table_lookup,
// with random gaps on both streams; checking is done by case_map_checker.
// Depends on crtl_pkg, case_map_checker and the RTL.

module tb_case_run_table_lookup;
   import crtl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUNS   = 512;
   localparam int SETTLE = 16;
   localparam int LIMIT  = 1_000_000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we;
   logic                   csr_index;
   logic [COUNT_W-1:0]     csr_wdata;
   int                     fail_count;
   int                     pending;
   int                     cycle_count;
   bit                     steady_req;

   // what the stimulus has put in each table, used to aim queries at runs
   run_entry_type loaded_runs [2][RUNS];
   int            run_count [2];

   case_run_table_lookup #(.RUNS_PER_TABLE(RUNS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   case_map_checker #(.RUNS_PER_TABLE(RUNS)) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly no gap, sometimes short, rarely long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [DELTA_W-1:0] pick_delta();
      logic signed [DELTA_W-1:0] v;
      int                        r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         v = '0;
      end else if (r < 35) begin
         v = DELTA_W'($urandom_range(1, 64));
         if ($urandom_range(0, 1) == 1) v = -v;
      end else if (r < 45) begin
         v = ($urandom_range(0, 1) == 1) ? 17'h10000 : 17'h0FFFF;
      end else begin
         v = DELTA_W'($urandom_range(0, 17'h1FFFF));
      end
      return v;
   endfunction

   // code point near a loaded run edge, or anywhere in the 21-bit field
   function automatic logic [CODE_W-1:0] pick_code(input logic sel);
      run_entry_type run;
      int            n;
      n = (run_count[sel] > RUNS) ? RUNS : run_count[sel];
      if (n == 0 || $urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return CODE_MAX;
            2: return 21'h1FFFFF;
            default: return CODE_W'($urandom_range(0, 21'h1FFFFF));
         endcase
      end
      run = loaded_runs[sel][$urandom_range(0, n - 1)];
      case ($urandom_range(0, 4))
         0: return run.first;
         1: return run.last;
         2: return run.first - 1'b1;
         3: return run.last + 1'b1;
         default: begin
            if (run.last >= run.first) begin
               return CODE_W'(run.first + $urandom_range(0, run.last - run.first));
            end
            return run.first;
         end
      endcase
   endfunction

   // one request beat, entered and left at a falling edge
   task automatic send_beat(input req_item_type it);
      int gap;
      gap = steady_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata         = '0;
      req_tdata[8:0]    = it.entry_index;
      req_tdata[29:9]   = it.run_start;
      req_tdata[50:30]  = it.run_end;
      req_tdata[51]     = it.every_other;
      req_tdata[68:52]  = it.run_delta;
      req_tdata[89:69]  = it.code_point;
      req_tuser         = {it.table_sel, it.func};
      req_tvalid        = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_run(input logic sel, input int idx, input logic [CODE_W-1:0] start_cp,
                           input logic [CODE_W-1:0] end_cp, input logic alt,
                           input logic signed [DELTA_W-1:0] delta);
      req_item_type it;
      it.func        = FUNC_LOAD;
      it.table_sel   = sel;
      it.entry_index = idx[INDEX_W-1:0];
      it.run_start   = start_cp;
      it.run_end     = end_cp;
      it.every_other = alt;
      it.run_delta   = delta;
      it.code_point  = CODE_W'($urandom_range(0, 21'h1FFFFF));
      loaded_runs[sel][idx].first = start_cp;
      loaded_runs[sel][idx].last  = end_cp;
      loaded_runs[sel][idx].alt   = alt;
      loaded_runs[sel][idx].delta = delta;
      send_beat(it);
   endtask

   // load fields carry random junk on a query
   task automatic query_code(input logic sel, input logic [CODE_W-1:0] cp);
      req_item_type it;
      it.func        = FUNC_QUERY;
      it.table_sel   = sel;
      it.entry_index = INDEX_W'($urandom_range(0, RUNS - 1));
      it.run_start   = CODE_W'($urandom_range(0, 21'h1FFFFF));
      it.run_end     = CODE_W'($urandom_range(0, 21'h1FFFFF));
      it.every_other = 1'($urandom_range(0, 1));
      it.run_delta   = DELTA_W'($urandom_range(0, 17'h1FFFF));
      it.code_point  = cp;
      send_beat(it);
   endtask

   // sorted, non-overlapping runs spread over the code space in slots 0..n-1
   task automatic build_table(input logic sel, input int n);
      int                span, base, len_cap, len, i;
      logic [CODE_W-1:0] f, l;
      if (n > RUNS) n = RUNS;
      if (n == 0) return;
      span = 32'h110000 / n;
      for (i = 0; i < n; i++) begin
         base    = i * span;
         len_cap = span / 2 - 1;
         f       = CODE_W'(base + $urandom_range(0, span / 2));
         if ($urandom_range(0, 9) < 7) len = $urandom_range(0, (len_cap < 40) ? len_cap : 40);
         else len = $urandom_range(0, len_cap);
         l = CODE_W'(f + len);
         if (i == 0 && $urandom_range(0, 3) == 0) f = '0;
         if (i == n - 1 && $urandom_range(0, 3) == 0) l = CODE_MAX;
         load_run(sel, i, f, l, $urandom_range(0, 3) == 0, pick_delta());
      end
   endtask

   // stop sending until every result is back, then let the block settle
   task automatic wait_idle(input int settle);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input int value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value[COUNT_W-1:0];
      run_count[idx] = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // result side back-pressure
   initial begin : rsp_stall
      int g;
      rsp_tready = 1'b1;
      forever begin
         repeat ($urandom_range(1, 40)) @(negedge clock);
         g = pick_gap();
         if (g > 0) begin
            rsp_tready = 1'b0;
            repeat (g) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   // run-away guard
   initial begin : watchdog
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int   p, i, qn, upper_n, lower_n;
      logic sel;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_UPPER_COUNT;
      csr_wdata  = '0;
      steady_req = 1'b0;
      run_count[0] = 0;
      run_count[1] = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: empty tables, then a small hand-made table of each kind
      query_code(TABLE_UPPER, 21'h000041);
      query_code(TABLE_LOWER, 21'h1FFFFF);
      load_run(TABLE_UPPER, 0, 21'h000010, 21'h000020, 1'b0, 17'h10000);  // most negative delta
      load_run(TABLE_UPPER, 1, 21'h000041, 21'h00005A, 1'b0, 17'sd32);
      load_run(TABLE_UPPER, 2, 21'h000100, 21'h00012F, 1'b1, 17'sd1);
      load_run(TABLE_UPPER, 3, 21'h000200, 21'h000210, 1'b0, 17'sd0);
      load_run(TABLE_UPPER, 4, 21'h10FF00, 21'h10FFFF, 1'b0, 17'h0FFFF);  // most positive delta
      load_run(TABLE_LOWER, 0, 21'h000061, 21'h00007A, 1'b0, -17'sd32);
      load_run(TABLE_LOWER, 1, 21'h10FFFF, 21'h10FFFF, 1'b1, -17'sd1);
      wait_idle(SETTLE);
      write_reg(CSR_UPPER_COUNT, 5);
      write_reg(CSR_LOWER_COUNT, 2);
      query_code(TABLE_UPPER, 21'h000010);  // sum below zero
      query_code(TABLE_UPPER, 21'h000041);
      query_code(TABLE_UPPER, 21'h00005A);
      query_code(TABLE_UPPER, 21'h000100);  // even offset, mapped
      query_code(TABLE_UPPER, 21'h000101);  // odd offset, not mapped
      query_code(TABLE_UPPER, 21'h000205);  // zero delta
      query_code(TABLE_UPPER, 21'h10FFFF);  // sum above range
      query_code(TABLE_UPPER, 21'h1FFFFF);  // beyond Unicode, no run
      query_code(TABLE_UPPER, 21'h000000);
      query_code(TABLE_UPPER, 21'h000030);  // gap between runs
      query_code(TABLE_LOWER, 21'h000061);
      query_code(TABLE_LOWER, 21'h10FFFF);
      query_code(TABLE_LOWER, 21'h1FFFFF);

      // random phases: rebuild tables, set counts, then mostly queries
      for (p = 0; p < 10; p++) begin
         steady_req = ($urandom_range(0, 3) == 0);
         upper_n = (p == 2) ? RUNS : (p == 3) ? 1023 : (p == 7) ? 0 : $urandom_range(1, 24);
         lower_n = (p == 5) ? RUNS : (p == 6) ? 1023 : (p == 1) ? 0 : $urandom_range(1, 24);
         // a saturated count reuses the full table built in the phase before
         if (upper_n != 1023) build_table(TABLE_UPPER, upper_n);
         if (lower_n != 1023) build_table(TABLE_LOWER, lower_n);
         wait_idle(SETTLE);
         write_reg(CSR_UPPER_COUNT, upper_n);
         write_reg(CSR_LOWER_COUNT, lower_n);
         qn = $urandom_range(40, 70);
         for (i = 0; i < qn; i++) begin
            if (i == qn / 2 && (p == 0 || $urandom_range(0, 1) == 1)) wait_idle(0);
            sel = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 8) begin
               // stray load: any slot, any content, may unsort a table
               load_run(sel, $urandom_range(0, RUNS - 1), CODE_W'($urandom_range(0, CODE_MAX)),
                        CODE_W'($urandom_range(0, CODE_MAX)), 1'($urandom_range(0, 1)),
                        pick_delta());
            end else begin
               query_code(sel, pick_code(sel));
            end
         end
      end

      wait_idle(SETTLE);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
